// File: src/dr_pkg.sv
// ----------------------------------------------------------------------------
// dr_pkg: shared constants and a helper for the difficulty retarget block
// Register indexes, reset values and the compact target decoder.
// ----------------------------------------------------------------------------
package dr_pkg;

  localparam int MAX_BITS   = 256;
  localparam int ELAPSED_W  = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int WORD_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_RETARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESPAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd2;

  localparam logic [WORD_W-1:0] TIMESPAN_RESET = 32'd1209600;
  localparam logic [WORD_W-1:0] LIMIT_RESET    = 32'h1d00ffff;

  // Expand compact bits to a full-width target; sign bit is ignored.
  function automatic logic [MAX_BITS-1:0] compact_decode(input logic [WORD_W-1:0] bits);
    logic [7:0]          size;
    logic [MAX_BITS-1:0] mant;
    logic [10:0]         sh;
    logic [MAX_BITS-1:0] res;
    size = bits[31:24];
    mant = MAX_BITS'(bits[22:0]);
    if (size <= 8'd3) begin
      sh  = {6'b000000, 2'(8'd3 - size), 3'b000};
      res = mant >> sh;
    end else begin
      sh  = {size - 8'd3, 3'b000};
      res = mant << sh;
    end
    return res;
  endfunction

endpackage

// File: src/dr_front.sv
// ----------------------------------------------------------------------------
// dr_front: entry stage
// Clamps the elapsed time and decodes the incoming compact target.
// ----------------------------------------------------------------------------
module dr_front #(
  parameter int TB = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [31:0]                   last_bits,
  input  logic [31:0]                   last_time,
  input  logic [31:0]                   first_time,
  input  logic [31:0]                   timespan,
  output logic                          valid,
  output logic [TB-1:0]                 acc,
  output logic [TB-1:0]                 mcand,
  output logic [dr_pkg::ELAPSED_W-1:0]  elapsed,
  output logic [31:0]                   bits
);
  import dr_pkg::*;

  logic signed [34:0] diff;
  logic signed [34:0] lo;
  logic signed [34:0] hi;
  logic signed [34:0] clamped;
  logic [MAX_BITS-1:0] dec;

  always_comb begin
    diff = $signed({3'b000, last_time}) - $signed({3'b000, first_time});
    lo   = $signed({5'b00000, timespan[31:2]});
    hi   = $signed({1'b0, timespan, 2'b00});
    clamped = diff;
    if (clamped < lo) clamped = lo;
    if (clamped > hi) clamped = hi;
    dec = compact_decode(last_bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc     <= '0;
      mcand   <= dec[TB-1:0];
      elapsed <= clamped[ELAPSED_W-1:0];
      bits    <= last_bits;
    end
  end

endmodule

// File: src/dr_mul_cell.sv
// ----------------------------------------------------------------------------
// dr_mul_cell: one shift-add step of the target by elapsed-time product
// Adds the multiplicand on the low multiplier bit, then shifts both along.
// ----------------------------------------------------------------------------
module dr_mul_cell #(
  parameter int TB = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [TB-1:0]                 acc_in,
  input  logic [TB-1:0]                 mcand_in,
  input  logic [dr_pkg::ELAPSED_W-1:0]  mult_in,
  input  logic [31:0]                   bits_in,
  output logic                          valid,
  output logic [TB-1:0]                 acc,
  output logic [TB-1:0]                 mcand,
  output logic [dr_pkg::ELAPSED_W-1:0]  mult,
  output logic [31:0]                   bits
);
  import dr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc   <= mult_in[0] ? acc_in + mcand_in : acc_in;
      mcand <= {mcand_in[TB-2:0], 1'b0};
      mult  <= {1'b0, mult_in[ELAPSED_W-1:1]};
      bits  <= bits_in;
    end
  end

endmodule

// File: src/dr_div_cell.sv
// ----------------------------------------------------------------------------
// dr_div_cell: one restoring division step by the timespan
// Shifts one dividend bit into the remainder and one quotient bit in below.
// ----------------------------------------------------------------------------
module dr_div_cell #(
  parameter int TB = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [31:0]    divisor,
  input  logic           valid_in,
  input  logic [31:0]    rem_in,
  input  logic [TB-1:0]  word_in,
  input  logic [31:0]    bits_in,
  output logic           valid,
  output logic [31:0]    rem,
  output logic [TB-1:0]  word,
  output logic [31:0]    bits
);
  import dr_pkg::*;

  logic [32:0] part;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    part = {rem_in, word_in[TB-1]};
    diff = part - {1'b0, divisor};
    ge   = part >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[31:0] : part[31:0];
      word <= {word_in[TB-2:0], ge};
      bits <= bits_in;
    end
  end

endmodule

// File: src/dr_back.sv
// ----------------------------------------------------------------------------
// dr_back: exit stages, with a bypass when retargeting is off
// Caps the quotient at the limit, finds its byte length and re-encodes it.
// ----------------------------------------------------------------------------
module dr_back #(
  parameter int TB = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           no_retarget,
  input  logic [31:0]    timespan,
  input  logic [31:0]    limit_bits,
  input  logic           valid_in,
  input  logic [TB-1:0]  quot_in,
  input  logic [31:0]    bits_in,
  output logic           valid,
  output logic [31:0]    new_bits
);
  import dr_pkg::*;

  localparam int NB = (TB + 7) / 8;
  localparam int PW = NB * 8;
  localparam int SW = $clog2(NB + 2);

  logic [MAX_BITS-1:0] lim_full;
  logic [TB-1:0]       lim;
  logic [TB-1:0]       capped;

  logic                v1;
  logic [PW-1:0]       val1;
  logic [31:0]         bits1;
  logic [SW-1:0]       size_c;

  logic                v2;
  logic [PW-1:0]       val2;
  logic [31:0]         bits2;
  logic [SW-1:0]       size2;

  logic [PW-1:0]       shifted;
  logic [31:0]         mant;
  logic [7:0]          size_out;
  logic [31:0]         enc;

  always_comb begin
    lim_full = compact_decode(limit_bits);
    lim      = lim_full[TB-1:0];
    capped   = (timespan == '0) ? '0 : quot_in;
    if (capped > lim) capped = lim;
  end

  // highest nonzero byte sets the length
  always_comb begin
    size_c = '0;
    for (int b = 0; b < NB; b++) begin
      if (val1[8*b +: 8] != 8'd0) size_c = SW'(b + 1);
    end
  end

  always_comb begin
    if (size2 <= SW'(3)) begin
      shifted = '0;
      mant    = {8'd0, val2[23:0]} << {2'(SW'(3) - size2), 3'b000};
    end else begin
      shifted = val2 >> {size2 - SW'(3), 3'b000};
      mant    = {8'd0, shifted[23:0]};
    end
    size_out = 8'(size2);
    if (mant[23]) begin
      mant     = {8'd0, mant[31:8]};
      size_out = size_out + 8'd1;
    end
    enc = {size_out, mant[23:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= valid_in;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val1     <= PW'(capped);
      bits1    <= bits_in;
      val2     <= val1;
      size2    <= size_c;
      bits2    <= bits1;
      new_bits <= no_retarget ? bits2 : enc;
    end
  end

endmodule

// File: src/difficulty_retarget_top.sv
// Throughput: one word per cycle; the multiply is a row of 34 shift-add cells
// and the divide a row of TARGET_BITS restoring cells, all advancing together.
// A stalled result freezes the whole row. Reset (rst, synchronous) clears all
// valid flags and loads the register reset values; payload is not cleared.
// ----------------------------------------------------------------------------
// difficulty_retarget_top: compact target retarget pipeline
// Clamp, multiply, divide, cap and re-encode a compact difficulty target.
// ----------------------------------------------------------------------------
module difficulty_retarget_top #(
  parameter int TARGET_BITS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   last_bits,
  input  logic [31:0]                   last_time,
  input  logic [31:0]                   first_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   new_bits,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data
);
  import dr_pkg::*;

  localparam int TB = TARGET_BITS;
  localparam int NM = ELAPSED_W;

  logic        no_retarget;
  logic [31:0] timespan;
  logic [31:0] limit_bits;
  logic        en;

  logic                 mv [NM+1];
  logic [TB-1:0]        macc [NM+1];
  logic [TB-1:0]        mcand [NM+1];
  logic [ELAPSED_W-1:0] mmul [NM+1];
  logic [31:0]          mbits [NM+1];

  logic          dv [TB+1];
  logic [31:0]   drem [TB+1];
  logic [TB-1:0] dword [TB+1];
  logic [31:0]   dbits [TB+1];

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_retarget <= 1'b0;
      timespan    <= TIMESPAN_RESET;
      limit_bits  <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NO_RETARGET: no_retarget <= cfg_data[0];
        CFG_TIMESPAN:    timespan    <= cfg_data;
        CFG_LIMIT:       limit_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  dr_front #(.TB(TB)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .last_bits(last_bits), .last_time(last_time),
    .first_time(first_time), .timespan(timespan),
    .valid(mv[0]), .acc(macc[0]), .mcand(mcand[0]), .elapsed(mmul[0]), .bits(mbits[0])
  );

  for (genvar i = 0; i < NM; i++) begin : g_mul
    dr_mul_cell #(.TB(TB)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(mv[i]), .acc_in(macc[i]), .mcand_in(mcand[i]),
      .mult_in(mmul[i]), .bits_in(mbits[i]),
      .valid(mv[i+1]), .acc(macc[i+1]), .mcand(mcand[i+1]),
      .mult(mmul[i+1]), .bits(mbits[i+1])
    );
  end

  assign dv[0]    = mv[NM];
  assign drem[0]  = '0;
  assign dword[0] = macc[NM];
  assign dbits[0] = mbits[NM];

  for (genvar i = 0; i < TB; i++) begin : g_div
    dr_div_cell #(.TB(TB)) u_cell (
      .clk(clk), .rst(rst), .en(en), .divisor(timespan),
      .valid_in(dv[i]), .rem_in(drem[i]), .word_in(dword[i]), .bits_in(dbits[i]),
      .valid(dv[i+1]), .rem(drem[i+1]), .word(dword[i+1]), .bits(dbits[i+1])
    );
  end

  dr_back #(.TB(TB)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .no_retarget(no_retarget), .timespan(timespan), .limit_bits(limit_bits),
    .valid_in(dv[TB]), .quot_in(dword[TB]), .bits_in(dbits[TB]),
    .valid(out_valid), .new_bits(new_bits)
  );

endmodule
